### rtl/core/ttr_pkg.sv
`default_nettype none

package ttr_pkg;

  // Sizes of the delimiter window and the receive buffer
  localparam int unsigned TokenBytes = 8;
  localparam int unsigned TokenIdxW  = $clog2(TokenBytes);
  localparam int unsigned LenW       = 4;
  localparam int unsigned BufferDepth = 1024;
  localparam int unsigned IdxW       = $clog2(BufferDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned TickW      = 16;

  typedef logic [7:0] byte_t;

  // Input item kinds
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // Reception status codes
  typedef enum logic [1:0] {
    ST_RECEIVING = 2'd0,
    ST_TOKEN     = 2'd1,
    ST_FULL      = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TOKEN_BYTES   = 2'd0,
    CFG_TOKEN_LENGTH  = 2'd1,
    CFG_BUFFER_LIMIT  = 2'd2,
    CFG_TIMEOUT_TICKS = 2'd3
  } cfg_idx_e;

  // Window control from the receiver to the cell row
  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/ttr_cell.sv
`default_nettype none

// One byte of the sliding window: holds a byte, takes its neighbor's byte
// on a shift and checks the byte it is about to hold against its token byte.
module ttr_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ttr_pkg::win_ctrl_t ctrl_i,
  input  wire ttr_pkg::byte_t    byte_i,
  input  wire ttr_pkg::byte_t    want_i,
  input  wire logic              used_i,
  output ttr_pkg::byte_t         byte_o,
  output logic                   hit_o
);

  ttr_pkg::byte_t byte_d, byte_q;

  // Compare on the incoming value; unused cells always agree
  assign hit_o  = !used_i || (byte_i == want_i);
  assign byte_o = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ttr_window.sv
`default_nettype none

// Row of byte cells, newest byte in cell 0. Reports whether the window
// after the pending shift ends with the configured token.
module ttr_window (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ttr_pkg::win_ctrl_t           ctrl_i,
  input  wire ttr_pkg::byte_t               byte_i,
  input  wire logic [ttr_pkg::TokenBytes*8-1:0] token_i,
  input  wire logic [ttr_pkg::LenW-1:0]     len_i,
  output logic                              hit_o
);

  ttr_pkg::byte_t [ttr_pkg::TokenBytes:0]   chain;
  logic [ttr_pkg::TokenBytes-1:0]           hits;

  assign chain[0] = byte_i;

  for (genvar j = 0; j < ttr_pkg::TokenBytes; j++) begin : g_cell
    logic [ttr_pkg::LenW-1:0] tidx;
    ttr_pkg::byte_t           want;
    logic                     used;

    // Cell j lines up with token byte len-1-j
    assign tidx = len_i - ttr_pkg::LenW'(j) - ttr_pkg::LenW'(1);
    assign used = (ttr_pkg::LenW'(j) < len_i);
    assign want = token_i[tidx[ttr_pkg::TokenIdxW-1:0]*8 +: 8];

    ttr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .byte_i (chain[j]),
      .want_i (want),
      .used_i (used),
      .byte_o (chain[j+1]),
      .hit_o  (hits[j])
    );
  end

  assign hit_o = &hits;

endmodule

`default_nettype wire

### rtl/core/token_terminated_receiver.sv
// Delimiter-terminated byte receiver with timeout.
//
// Input stream: s_axis_tuser_i carries the item kind (start, byte, tick) and
// s_axis_tdata_i the received byte. Each accepted beat gives exactly one
// result beat on the master side: a buffer write (valid, index, byte), the
// reception status and the stored byte count.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write one register a
// beat; cfg_ready_o is always high. Write only while the block is idle.
// The result beat appears in the cycle after its input beat; one item is
// taken every cycle unless the result side stalls. The delimiter compare
// runs in a row of eight byte cells that shift together, in each byte's cycle.
// The result sits in an output register; s_axis_tready_o stays high while
// that register is empty or is being drained, so a stalled receiver holds
// back the input after one result waits.
// Reset clears the window, counts and status (as if a start had occurred)
// and restores the registers: token length 0, limit 16, timeout 1000.
`default_nettype none

module token_terminated_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // input items
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // rx_byte[7:0]
  input  wire logic [1:0]  s_axis_tuser_i,   // func[1:0]
  // result items
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // write_index[9:0], write_byte[17:10],
                                             // byte_count[28:18], zero[31:29]
  output logic [2:0]       m_axis_tuser_o    // write_valid[0], status[2:1]
);

  localparam int unsigned CntW  = ttr_pkg::CntW;
  localparam int unsigned IdxW  = ttr_pkg::IdxW;
  localparam int unsigned TickW = ttr_pkg::TickW;
  localparam int unsigned LenW  = ttr_pkg::LenW;

  // Configuration registers
  logic [63:0]      token_q;
  logic [LenW-1:0]  tlen_q;
  logic [CntW-1:0]  limit_q;
  logic [TickW-1:0] timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q   <= '0;
      tlen_q    <= '0;
      limit_q   <= CntW'(16);
      timeout_q <= TickW'(1000);
    end else if (cfg_valid_i) begin
      unique case (ttr_pkg::cfg_idx_e'(cfg_index_i))
        ttr_pkg::CFG_TOKEN_BYTES:   token_q   <= cfg_data_i;
        ttr_pkg::CFG_TOKEN_LENGTH:  tlen_q    <= cfg_data_i[LenW-1:0];
        ttr_pkg::CFG_BUFFER_LIMIT:  limit_q   <= cfg_data_i[CntW-1:0];
        ttr_pkg::CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Reception state
  logic [CntW-1:0]   count_d, count_q;
  logic [TickW-1:0]  ticks_d, ticks_q;
  logic              done_d, done_q;
  ttr_pkg::status_e  status_d, status_q;

  logic              in_fire;
  logic              out_valid_q;
  ttr_pkg::win_ctrl_t win_ctrl;
  logic              win_hit;

  logic [LenW-1:0]   len_sat;
  logic [CntW-1:0]   limit_eff;
  logic [CntW-1:0]   count_inc;
  logic [TickW-1:0]  ticks_inc;

  logic              wr_valid;
  logic [IdxW-1:0]   wr_index;
  ttr_pkg::byte_t    wr_byte;
  ttr_pkg::status_e  status_out;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign len_sat   = (tlen_q > LenW'(ttr_pkg::TokenBytes)) ?
                     LenW'(ttr_pkg::TokenBytes) : tlen_q;
  assign limit_eff = (limit_q > CntW'(ttr_pkg::BufferDepth)) ?
                     CntW'(ttr_pkg::BufferDepth) : limit_q;
  assign count_inc = count_q + CntW'(1);
  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + TickW'(1);

  ttr_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .byte_i  (s_axis_tdata_i),
    .token_i (token_q),
    .len_i   (len_sat),
    .hit_o   (win_hit)
  );

  // Item handling
  always_comb begin
    count_d  = count_q;
    ticks_d  = ticks_q;
    done_d   = done_q;
    status_d = status_q;
    win_ctrl = '0;
    wr_valid = 1'b0;
    wr_index = '0;
    wr_byte  = '0;
    if (in_fire) begin
      unique case (ttr_pkg::func_e'(s_axis_tuser_i))
        ttr_pkg::FUNC_START: begin
          count_d        = '0;
          ticks_d        = '0;
          done_d         = 1'b0;
          status_d       = ttr_pkg::ST_RECEIVING;
          win_ctrl.clear = 1'b1;
        end
        ttr_pkg::FUNC_BYTE: begin
          if (!done_q) begin
            if (count_q >= limit_eff) begin
              done_d   = 1'b1;
              status_d = ttr_pkg::ST_FULL;
            end else begin
              wr_valid       = 1'b1;
              wr_index       = count_q[IdxW-1:0];
              wr_byte        = s_axis_tdata_i;
              count_d        = count_inc;
              win_ctrl.shift = 1'b1;
              if ((len_sat != '0) && (count_inc >= CntW'(len_sat)) && win_hit) begin
                done_d   = 1'b1;
                status_d = ttr_pkg::ST_TOKEN;
              end
            end
          end
        end
        ttr_pkg::FUNC_TICK: begin
          if (!done_q && (timeout_q != '0)) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= timeout_q) begin
              done_d   = 1'b1;
              status_d = ttr_pkg::ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
    status_out = done_d ? status_d : ttr_pkg::ST_RECEIVING;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ticks_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ttr_pkg::ST_RECEIVING;
    end else begin
      count_q  <= count_d;
      ticks_q  <= ticks_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // Output register
  logic             out_valid_d;
  logic [31:0]      out_data_q;
  logic [2:0]       out_user_q;

  assign out_valid_d = in_fire || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {3'b000, count_d, wr_byte, wr_index};
      out_user_q <= {status_out, wr_valid};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire
